### design/sli_pkg.sv
// Package for the sorted insertion list: capacity, count width, status codes
// and the request word handed to every storage cell. No dependencies.
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int ENTRY_W  = 5;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } sli_status_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // Request broadcast to the row of cells in the cycle a word is accepted.
    typedef struct packed {
        logic                       ins_en;
        logic                       del_en;
        logic signed [VALUE_W-1:0]  value;
    } sli_op_t;

endpackage

### design/sli_cell.sv
// One storage cell of the sorted insertion list: holds a value, compares it
// with the request operand and shifts left or right with its neighbors. Uses sli_pkg.
module sli_cell import sli_pkg::*; (
    input  logic                       aclk,
    input  sli_op_t                    op,
    input  logic                       occ,
    input  logic                       left_less,
    input  logic signed [VALUE_W-1:0]  left_value,
    input  logic signed [VALUE_W-1:0]  right_value,
    output logic signed [VALUE_W-1:0]  value,
    output logic                       less,
    output logic                       hit
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      at_pos;

    // The cell is the insertion or deletion point when all cells to its left
    // hold smaller values and this one does not.
    assign less   = occ && (value_reg < op.value);
    assign at_pos = left_less && !less;
    assign hit    = occ && at_pos && (value_reg == op.value);
    assign value  = value_reg;

    // Insert shifts the upper part right; delete shifts it left.
    always_comb begin
        value_next = value_reg;
        if (op.ins_en) begin
            if (at_pos) begin
                value_next = op.value;
            end else if (!left_less) begin
                value_next = left_value;
            end
        end else if (op.del_en && !less) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

### design/sorted_list_insert_delete.sv
// Sorted insertion list: a row of CAPACITY cells plus count and result logic.
// Depends on sli_pkg and sli_cell.
//
// Usage:
//   Request words arrive on s_valid/s_ready with s_req_type (0 insert,
//   1 delete first equal value) and a signed 32-bit s_value. Each request
//   produces one result word on m_valid/m_ready carrying m_status and
//   m_entry_count, the number of stored values after the request.
//   All cells compare against the operand in parallel and shift in the same
//   cycle; the result is registered and shows in the cycle after acceptance.
//   Throughput is one word per cycle while the receiver takes each result,
//   set by the parallel compare and shift of the cell row and the result register.
//   A new request is taken in the cycle the pending result is taken, so a
//   stalled receiver holds the result and the input channel stops with it.
//   Inserting into a full list drops the value and reports full; deleting an
//   absent value or from an empty list reports not found.
//   Reset (aresetn low, synchronous) clears the count, which empties the list,
//   and drops any pending result. Cell contents are not cleared; only cells
//   below the count are ever compared.
module sorted_list_insert_delete import sli_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_req_type,
    input  logic signed [VALUE_W-1:0]  s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [ENTRY_W-1:0]         m_entry_count
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic [1:0]         status_next;
    logic [ENTRY_W-1:0] m_entry_count_reg;

    logic                       accept;
    logic                       full;
    logic                       found;
    sli_op_t                    op;
    logic [CAPACITY-1:0]        occ;
    logic [CAPACITY-1:0]        less;
    logic [CAPACITY-1:0]        hit;
    logic signed [VALUE_W-1:0]  cell_value [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == COUNT_W'(CAPACITY));
    assign found   = |hit;

    // Request word broadcast to every cell.
    always_comb begin
        op.value  = s_value;
        op.ins_en = accept && (s_req_type == REQ_INSERT) && !full;
        op.del_en = accept && (s_req_type == REQ_DELETE) && found;
    end

    // Row of cells; the ends see a smaller-than flag of one on the left and
    // filler data at the open sides.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                      left_less_w;
        logic signed [VALUE_W-1:0] left_value_w;
        logic signed [VALUE_W-1:0] right_value_w;

        assign occ[i] = count_reg > COUNT_W'(i);

        if (i == 0) begin : g_first
            assign left_less_w  = 1'b1;
            assign left_value_w = s_value;
        end else begin : g_mid
            assign left_less_w  = less[i-1];
            assign left_value_w = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value_w = cell_value[i];
        end else begin : g_inner
            assign right_value_w = cell_value[i+1];
        end

        sli_cell u_cell (
            .aclk        (aclk),
            .op          (op),
            .occ         (occ[i]),
            .left_less   (left_less_w),
            .left_value  (left_value_w),
            .right_value (right_value_w),
            .value       (cell_value[i]),
            .less        (less[i]),
            .hit         (hit[i])
        );
    end

    // Count update and status for the accepted word.
    always_comb begin
        count_next  = count_reg;
        status_next = ST_NOT_FOUND;
        if (s_req_type == REQ_INSERT) begin
            if (full) begin
                status_next = ST_FULL;
            end else begin
                status_next = ST_INSERTED;
                count_next  = count_reg + COUNT_W'(1);
            end
        end else if (found) begin
            status_next = ST_DELETED;
            count_next  = count_reg - COUNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg      <= status_next;
            m_entry_count_reg <= ENTRY_W'(count_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;

    // The count never runs past the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("stored count exceeds capacity");

    // An accepted word always yields a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted word produced no result");

    // A successful insert grows the count by one.
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req_type == REQ_INSERT && !full)
        |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("insert did not grow the count");

    // A successful delete shrinks the count by one.
    a_delete_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req_type == REQ_DELETE && found)
        |=> count_reg == $past(count_reg) - COUNT_W'(1))
        else $error("delete did not shrink the count");

    // At most one cell matches as the first equal value.
    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit))
        else $error("more than one cell matched for delete");

endmodule

### tb/sorted_list_insert_delete_tb.sv
// Self-checking testbench for the sorted insertion list: directed table, then random
// insert and delete traffic under several idling patterns. Depends on sli_pkg and the RTL.
`timescale 1ns / 100ps

module sorted_list_insert_delete_tb import sli_pkg::*;;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_WORDS    = 232;

    typedef struct packed {
        sli_status_t          status;
        logic [ENTRY_W-1:0]   count;
    } list_result_t;

    typedef struct {
        logic                      req;
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        sli_status_t               status;
        int                        count;
    } table_row_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_req_type;
    logic signed [VALUE_W-1:0]  s_value;
    logic                       m_valid;
    logic                       m_ready;
    logic [1:0]                 m_status;
    logic [ENTRY_W-1:0]         m_entry_count;

    // Shadow copy of the list and the results still owed by the block.
    logic signed [VALUE_W-1:0]  shadow_vals [CAPACITY];
    int                         shadow_len;
    list_result_t               pending_results [$];

    int error_count;
    int words_sent;
    int results_checked;
    int status_seen [4];
    int send_idle_pct;
    int stall_pct;
    int quiet_cycles;

    // Directed words: empty list, extremes, equal values, a full list and misses.
    table_row_t directed_rows [24] = '{
        '{REQ_DELETE, 32'sd0,          1'b1, ST_NOT_FOUND, 0},
        '{REQ_INSERT, 32'sh7FFFFFFF,   1'b1, ST_INSERTED,  1},
        '{REQ_INSERT, 32'sh80000000,   1'b1, ST_INSERTED,  2},
        '{REQ_DELETE, 32'sd0,          1'b1, ST_NOT_FOUND, 2},
        '{REQ_INSERT, -32'sd1,         1'b1, ST_INSERTED,  3},
        '{REQ_INSERT, -32'sd1,         1'b1, ST_INSERTED,  4},
        '{REQ_INSERT, 32'sd0,          1'b1, ST_INSERTED,  5},
        '{REQ_INSERT, 32'sd1,          1'b1, ST_INSERTED,  6},
        '{REQ_INSERT, 32'sd100,        1'b0, ST_INSERTED,  0},
        '{REQ_INSERT, -32'sd100,       1'b0, ST_INSERTED,  0},
        '{REQ_INSERT, 32'sd7,          1'b0, ST_INSERTED,  0},
        '{REQ_INSERT, 32'sd7,          1'b0, ST_INSERTED,  0},
        '{REQ_INSERT, 32'sh40000000,   1'b0, ST_INSERTED,  0},
        '{REQ_INSERT, -32'sd7,         1'b0, ST_INSERTED,  0},
        '{REQ_INSERT, 32'sd3,          1'b0, ST_INSERTED,  0},
        '{REQ_INSERT, 32'sd2,          1'b0, ST_INSERTED,  0},
        '{REQ_INSERT, 32'sh7FFFFFFE,   1'b0, ST_INSERTED,  0},
        '{REQ_INSERT, 32'sh80000001,   1'b0, ST_INSERTED,  0},
        '{REQ_INSERT, 32'sd5,          1'b1, ST_FULL,      16},
        '{REQ_DELETE, -32'sd1,         1'b1, ST_DELETED,   15},
        '{REQ_DELETE, 32'sh80000000,   1'b1, ST_DELETED,   14},
        '{REQ_DELETE, 32'sh7FFFFFFF,   1'b1, ST_DELETED,   13},
        '{REQ_DELETE, 32'sh7FFFFFFF,   1'b1, ST_NOT_FOUND, 13},
        '{REQ_DELETE, 32'sd7,          1'b0, ST_DELETED,   0}
    };

    sorted_list_insert_delete u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

    // Clock with a 4 ns period.
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Applies one request to the shadow list and returns the status and new count.
    function automatic list_result_t apply_list_request(logic req,
                                                        logic signed [VALUE_W-1:0] value);
        list_result_t res;
        int           pos;
        pos = 0;
        while (pos < shadow_len && shadow_vals[pos] < value)
            pos++;
        if (req == REQ_INSERT) begin
            if (shadow_len >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                for (int i = shadow_len; i > pos; i--)
                    shadow_vals[i] = shadow_vals[i-1];
                shadow_vals[pos] = value;
                shadow_len++;
                res.status = ST_INSERTED;
            end
        end else begin
            if (pos >= shadow_len || shadow_vals[pos] != value) begin
                res.status = ST_NOT_FOUND;
            end else begin
                for (int i = pos; i + 1 < shadow_len; i++)
                    shadow_vals[i] = shadow_vals[i+1];
                shadow_len--;
                res.status = ST_DELETED;
            end
        end
        res.count = shadow_len[ENTRY_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Sends one request word; the prediction is queued once the word is taken.
    // Called just after a falling edge and returns just after one.
    task automatic send_request(logic req, logic signed [VALUE_W-1:0] value,
                                bit typed, list_result_t typed_res);
        list_result_t res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_value    <= value;
        forever begin
            @(posedge aclk);
            if (s_ready)
                break;
        end
        res = apply_list_request(req, value);
        if (typed)
            res = typed_res;
        pending_results.push_back(res);
        status_seen[res.status]++;
        words_sent++;
        @(negedge aclk);
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic wait_for_empty_queue();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    // Random request: drift toward a full or an empty list, deletes mostly hit.
    task automatic send_random_request(bit fill_bias);
        logic                      req;
        logic signed [VALUE_W-1:0] value;
        int                        pick;
        list_result_t              unused;
        unused = '0;
        req = ($urandom_range(0, 99) < (fill_bias ? 70 : 30)) ? REQ_INSERT : REQ_DELETE;
        pick = $urandom_range(0, 99);
        if (req == REQ_DELETE && shadow_len > 0 && pick < 70)
            value = shadow_vals[$urandom_range(0, shadow_len - 1)];
        else if (pick < 80)
            value = $signed($urandom_range(0, 15)) - 8;
        else if (pick < 95)
            value = $urandom;
        else
            value = pick[0] ? 32'sh7FFFFFFF : 32'sh80000000;
        send_request(req, value, 1'b0, unused);
    endtask

    // Receiver: ready drops at random according to the current stall rate.
    always @(negedge aclk) begin
        if (aresetn)
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Result checker: compares each accepted result word with the oldest prediction.
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, status", m_status, -1);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_entry_count !== want.count)
                    report_mismatch("entry count", m_entry_count, want.count);
            end
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d idle cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        list_result_t typed_res;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_req_type      = REQ_INSERT;
        s_value         = '0;
        m_ready         = 1'b0;
        shadow_len      = 0;
        error_count     = 0;
        words_sent      = 0;
        results_checked = 0;
        quiet_cycles    = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        status_seen     = '{0, 0, 0, 0};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed table.
        foreach (directed_rows[r]) begin
            typed_res.status = directed_rows[r].status;
            typed_res.count  = directed_rows[r].count[ENTRY_W-1:0];
            send_request(directed_rows[r].req, directed_rows[r].value,
                         directed_rows[r].typed, typed_res);
        end

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++) begin
            wait_for_empty_queue();
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 67; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 67; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
                send_random_request(((n / 48) % 2) == 0);
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results never returned", 0, pending_results.size());

        $display("Sent %0d request words, checked %0d results.", words_sent, results_checked);
        $display("Inserted %0d, deleted %0d, not found %0d, full and dropped %0d.",
                 status_seen[ST_INSERTED], status_seen[ST_DELETED],
                 status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
